// File: rtl/qgi_pkg.sv
// shared types, sequencer op codes and constants for the quaternion gyro integrator
package qgi_pkg;

    localparam int QGI_OPW = 40;  // multiplier operand width
    localparam int QGI_PRW = 80;  // product and accumulator width
    localparam int QGI_DVW = 64;  // dividend and quotient width
    localparam int QGI_DSW = 32;  // divisor width
    localparam int QGI_SQW = 64;  // square root radicand width

    typedef logic signed [QGI_OPW-1:0] t_opnd;
    typedef logic signed [QGI_PRW-1:0] t_prod;
    typedef logic [5:0] t_op;

    // sequencer program, one entry per shared-unit operation
    localparam t_op OP_DELTA0  = 6'd0;
    localparam t_op OP_DELTA2  = 6'd2;
    localparam t_op OP_SQ0     = 6'd3;
    localparam t_op OP_SQ2     = 6'd5;
    localparam t_op OP_HSQ     = 6'd6;
    localparam t_op OP_DIVB    = 6'd7;
    localparam t_op OP_DIVA    = 6'd8;
    localparam t_op OP_T0      = 6'd9;
    localparam t_op OP_T2      = 6'd11;
    localparam t_op OP_ROW0    = 6'd12;
    localparam t_op OP_ROW_LAST = 6'd27;
    localparam t_op OP_N2_0    = 6'd28;
    localparam t_op OP_N2_LAST = 6'd31;
    localparam t_op OP_Q0      = 6'd32;
    localparam t_op OP_LAST    = 6'd35;

    // (2^39 + 1) / 3: x * QGI_RCP3 >> 39 is floor(x / 3) for any x below 2^39
    localparam t_opnd QGI_RCP3 = 40'sd183251937963;
    localparam t_opnd QGI_ONE_Q30 = 40'sd1073741824;
    localparam logic signed [33:0] QGI_HALF_Q30 = 34'sd536870912;

    // quaternion product coefficient: a, or a signed t component
    typedef struct packed {
        logic       use_a;
        logic [1:0] tsel;
        logic       neg;
    } t_coef_sel;

    function automatic t_coef_sel qgi_coef(input logic [3:0] idx);
        t_coef_sel c;
        c = '{use_a: 1'b0, tsel: 2'd0, neg: 1'b0};
        case (idx)
            4'd0:  c = '{use_a: 1'b1, tsel: 2'd0, neg: 1'b0};
            4'd1:  c = '{use_a: 1'b0, tsel: 2'd0, neg: 1'b1};
            4'd2:  c = '{use_a: 1'b0, tsel: 2'd1, neg: 1'b1};
            4'd3:  c = '{use_a: 1'b0, tsel: 2'd2, neg: 1'b1};
            4'd4:  c = '{use_a: 1'b0, tsel: 2'd0, neg: 1'b0};
            4'd5:  c = '{use_a: 1'b1, tsel: 2'd0, neg: 1'b0};
            4'd6:  c = '{use_a: 1'b0, tsel: 2'd2, neg: 1'b0};
            4'd7:  c = '{use_a: 1'b0, tsel: 2'd1, neg: 1'b1};
            4'd8:  c = '{use_a: 1'b0, tsel: 2'd1, neg: 1'b0};
            4'd9:  c = '{use_a: 1'b0, tsel: 2'd2, neg: 1'b1};
            4'd10: c = '{use_a: 1'b1, tsel: 2'd0, neg: 1'b0};
            4'd11: c = '{use_a: 1'b0, tsel: 2'd0, neg: 1'b0};
            4'd12: c = '{use_a: 1'b0, tsel: 2'd2, neg: 1'b0};
            4'd13: c = '{use_a: 1'b0, tsel: 2'd1, neg: 1'b0};
            4'd14: c = '{use_a: 1'b0, tsel: 2'd0, neg: 1'b1};
            4'd15: c = '{use_a: 1'b1, tsel: 2'd0, neg: 1'b0};
            default: c = '{use_a: 1'b1, tsel: 2'd0, neg: 1'b0};
        endcase
        return c;
    endfunction

endpackage

// File: rtl/qgi_mul.sv
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
module qgi_mul import qgi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_opnd i_a,
    input  t_opnd i_b,
    output logic  o_done,
    output t_prod o_prod
);

    localparam int CW = $clog2(QGI_OPW);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    t_prod              r_mcand;
    t_prod              r_acc;
    logic [QGI_OPW-1:0] r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QGI_OPW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // negative multiplier: negate the multiplicand and use the magnitude
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= i_b[QGI_OPW-1] ? -t_prod'(i_a) : t_prod'(i_a);
            r_mplier <= i_b[QGI_OPW-1] ? QGI_OPW'(-i_b) : QGI_OPW'(i_b);
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: rtl/qgi_div.sv
// restoring unsigned divider, one quotient bit per cycle
module qgi_div import qgi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [QGI_DVW-1:0] i_dividend,
    input  logic [QGI_DSW-1:0] i_divisor,
    output logic               o_done,
    output logic [QGI_DVW-1:0] o_quo
);

    localparam int CW = $clog2(QGI_DVW);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [QGI_DSW-1:0] r_rem;
    logic [QGI_DSW-1:0] r_dsr;
    logic [QGI_DVW-1:0] r_quo;
    logic [QGI_DSW:0]   w_trial;
    logic [QGI_DSW:0]   w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_quo[QGI_DVW-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QGI_DVW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[QGI_DSW-1:0] : w_trial[QGI_DSW-1:0];
            r_quo <= {r_quo[QGI_DVW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/qgi_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
module qgi_sqrt import qgi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [QGI_SQW-1:0]   i_value,
    output logic                 o_done,
    output logic [QGI_SQW/2-1:0] o_root
);

    localparam int STEPS = QGI_SQW / 2;
    localparam int CW    = $clog2(STEPS);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [QGI_SQW-1:0] r_v;
    logic [QGI_SQW-1:0] r_res;
    logic [QGI_SQW-1:0] r_bit;
    logic [QGI_SQW-1:0] w_rb;

    assign w_rb = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
            r_bit <= {2'b01, {(QGI_SQW-2){1'b0}}};
        end else if (r_busy) begin
            if (r_v >= w_rb) begin
                r_v   <= r_v - w_rb;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[QGI_SQW/2-1:0];

endmodule

// File: rtl/quaternion_gyro_integrate.sv
// top level: sequencer and state for the gyro-driven attitude quaternion update
// Takes one gyro sample (Q4.12 rates, Q0.16 time step) and returns the new
// normalized attitude quaternion in Q2.30, starting from identity after reset.
// The time an item takes grows when a large rotation needs extra normalizing
// shifts and is set by the bit-serial multiplier (32 products, two of them
// reciprocal multiplications that stand in for the divisions by 48 and 384),
// the bit-serial divider (four normalizing divisions) and the 32-step square
// root, all run back to back by the sequencer. Input is not ready while an
// item is in work; a finished result waits in the output register and does
// not block the next input transfer.
// When the product norm is zero the stored attitude is kept and output again,
// and the divisions are skipped.
module quaternion_gyro_integrate import qgi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    input  logic signed [15:0] i_rate_z,
    input  logic        [15:0] i_time_step,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_quat_w,
    output logic signed [31:0] o_quat_x,
    output logic signed [31:0] o_quat_y,
    output logic signed [31:0] o_quat_z
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_WAIT  = 8'b0000_0100,
        S_ABS   = 8'b0000_1000,
        S_NORM  = 8'b0001_0000,
        S_SQRT  = 8'b0010_0000,
        S_SQW   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state             r_state;
    t_op                r_op;
    logic               r_out_valid;
    logic signed [15:0] r_rate [3];
    logic        [15:0] r_dt;
    logic signed [31:0] r_dl [3];
    t_prod              r_acc;
    logic        [37:0] r_d2;
    logic        [45:0] r_hsq;
    logic signed [33:0] r_b;
    t_opnd              r_a;
    t_opnd              r_t [3];
    logic        [49:0] r_u [4];
    logic        [3:0]  r_neg;
    logic        [63:0] r_n2;
    logic        [31:0] r_n;
    logic signed [31:0] r_att [4];
    logic signed [31:0] r_quat [4];

    t_opnd              w_mul_a;
    t_opnd              w_mul_b;
    t_prod              w_prod;
    t_prod              w_sum;
    logic               w_mul_done;
    logic               w_mul_start;
    logic               w_div_done;
    logic               w_div_start;
    logic [QGI_DVW-1:0] w_dividend;
    logic [QGI_DSW-1:0] w_divisor;
    logic [QGI_DVW-1:0] w_quo;
    logic               w_sqrt_done;
    logic [31:0]        w_root;
    logic               w_is_div;
    logic               w_is_row;
    logic               w_first;
    logic               w_unit_done;
    logic               w_big;
    t_op                w_rel_sq;
    t_op                w_rel_t;
    t_op                w_rel_row;
    t_op                w_rel_n2;
    t_op                w_rel_q;
    t_coef_sel          w_csel;
    logic [63:0]        w_lim;
    logic [31:0]        w_qv;

    assign w_rel_sq  = r_op - OP_SQ0;
    assign w_rel_t   = r_op - OP_T0;
    assign w_rel_row = r_op - OP_ROW0;
    assign w_rel_n2  = r_op - OP_N2_0;
    assign w_rel_q   = r_op - OP_Q0;
    assign w_csel    = qgi_coef(w_rel_row[3:0]);

    assign w_is_div = (r_op >= OP_Q0);
    assign w_is_row = (r_op >= OP_ROW0) && (r_op <= OP_ROW_LAST);
    assign w_first  = (r_op == OP_SQ0) || (r_op == OP_N2_0)
                    || (w_is_row && (w_rel_row[1:0] == 2'd0));
    assign w_unit_done = w_is_div ? w_div_done : w_mul_done;

    assign w_mul_start = (r_state == S_START) && !w_is_div;
    assign w_div_start = (r_state == S_START) && w_is_div;

    // operand selection for the shared multiplier
    always_comb begin
        t_opnd coef;
        coef    = w_csel.use_a ? r_a : r_t[w_csel.tsel];
        w_mul_a = '0;
        w_mul_b = '0;
        if (r_op <= OP_DELTA2) begin
            w_mul_a = t_opnd'(r_rate[r_op[1:0]]);
            w_mul_b = t_opnd'({1'b0, r_dt});
        end else if (r_op <= OP_SQ2) begin
            w_mul_a = t_opnd'(r_dl[w_rel_sq[1:0]]);
            w_mul_b = t_opnd'(r_dl[w_rel_sq[1:0]]);
        end else if (r_op == OP_HSQ) begin
            w_mul_a = t_opnd'({1'b0, r_d2[37:15]});
            w_mul_b = t_opnd'({1'b0, r_d2[37:15]});
        end else if (r_op == OP_DIVB) begin
            // d2 / 48 as (d2 >> 4) / 3
            w_mul_a = t_opnd'({1'b0, r_d2[37:4]});
            w_mul_b = QGI_RCP3;
        end else if (r_op == OP_DIVA) begin
            // d2sq / 384 as (d2sq >> 7) / 3
            w_mul_a = t_opnd'({1'b0, r_hsq[45:7]});
            w_mul_b = QGI_RCP3;
        end else if ((r_op >= OP_T0) && (r_op <= OP_T2)) begin
            w_mul_a = t_opnd'(r_b);
            w_mul_b = t_opnd'(r_dl[w_rel_t[1:0]]);
        end else if (w_is_row) begin
            w_mul_a = w_csel.neg ? -coef : coef;
            w_mul_b = t_opnd'(r_att[w_rel_row[1:0]]);
        end else if ((r_op >= OP_N2_0) && (r_op <= OP_N2_LAST)) begin
            w_mul_a = t_opnd'({1'b0, r_u[w_rel_n2[1:0]][30:0]});
            w_mul_b = t_opnd'({1'b0, r_u[w_rel_n2[1:0]][30:0]});
        end
    end

    assign w_dividend = QGI_DVW'({r_u[w_rel_q[1:0]][30:0], 30'd0});
    assign w_divisor  = r_n;

    assign w_sum = (w_first ? t_prod'(0) : r_acc) + w_prod;
    assign w_big = (|r_u[0][49:31]) | (|r_u[1][49:31]) | (|r_u[2][49:31])
                 | (|r_u[3][49:31]);

    // saturate the normalized magnitude to the signed 32-bit range
    assign w_lim = r_neg[w_rel_q[1:0]] ? 64'h0000_0000_8000_0000
                                       : 64'h0000_0000_7FFF_FFFF;
    assign w_qv  = (w_quo > w_lim) ? w_lim[31:0] : w_quo[31:0];

    qgi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    qgi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    qgi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQRT),
        .i_value (r_n2),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_DELTA0;
            r_out_valid <= 1'b0;
            r_att[0]    <= 32'sh4000_0000;
            r_att[1]    <= '0;
            r_att[2]    <= '0;
            r_att[3]    <= '0;
        end else begin
            if (r_out_valid && i_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= OP_DELTA0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_unit_done) begin
                        if (r_op >= OP_Q0) begin
                            r_att[w_rel_q[1:0]] <= r_neg[w_rel_q[1:0]] ? -w_qv : w_qv;
                        end
                        r_op <= r_op + 1'b1;
                        if (r_op == OP_ROW_LAST) begin
                            r_state <= S_ABS;
                        end else if (r_op == OP_N2_LAST) begin
                            r_state <= S_SQRT;
                        end else if (r_op == OP_LAST) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_START;
                        end
                    end
                end
                S_ABS: begin
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (!w_big) begin
                        r_op    <= OP_N2_0;
                        r_state <= S_START;
                    end
                end
                S_SQRT: begin
                    r_state <= S_SQW;
                end
                S_SQW: begin
                    if (w_sqrt_done) begin
                        if (w_root == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_op    <= OP_Q0;
                            r_state <= S_START;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_rate[0] <= i_rate_x;
            r_rate[1] <= i_rate_y;
            r_rate[2] <= i_rate_z;
            r_dt      <= i_time_step;
        end
        if ((r_state == S_WAIT) && w_unit_done) begin
            if (r_op <= OP_DELTA2) begin
                r_dl[r_op[1:0]] <= w_prod[31:0];
            end else if (r_op <= OP_SQ2) begin
                r_acc <= w_sum;
                if (r_op == OP_SQ2) begin
                    r_d2 <= w_sum[63:26];
                end
            end else if (r_op == OP_HSQ) begin
                r_hsq <= w_prod[45:0];
            end else if (r_op == OP_DIVB) begin
                r_b <= QGI_HALF_Q30 - $signed({1'b0, w_prod[71:39]});
            end else if (r_op == OP_DIVA) begin
                r_a <= QGI_ONE_Q30 - t_opnd'({1'b0, r_d2[37:3]})
                     + t_opnd'({1'b0, w_prod[76:39]});
            end else if (r_op <= OP_T2) begin
                r_t[w_rel_t[1:0]] <= w_prod[67:28];
            end else if (w_is_row) begin
                r_acc <= w_sum;
                if (w_rel_row[1:0] == 2'd3) begin
                    r_u[w_rel_row[3:2]]   <= w_sum[79:30];
                    r_neg[w_rel_row[3:2]] <= w_sum[79];
                end
            end else if (r_op <= OP_N2_LAST) begin
                r_acc <= w_sum;
                if (r_op == OP_N2_LAST) begin
                    r_n2 <= w_sum[63:0];
                end
            end
        end
        // row results are signed until here, magnitudes from here on
        if (r_state == S_ABS) begin
            for (int i = 0; i < 4; i++) begin
                r_u[i] <= r_neg[i] ? -r_u[i] : r_u[i];
            end
        end
        if ((r_state == S_NORM) && w_big) begin
            for (int i = 0; i < 4; i++) begin
                r_u[i] <= r_u[i] >> 1;
            end
        end
        if ((r_state == S_SQW) && w_sqrt_done) begin
            r_n <= w_root;
        end
        if ((r_state == S_OUT) && (!r_out_valid || i_ready)) begin
            for (int i = 0; i < 4; i++) begin
                r_quat[i] <= r_att[i];
            end
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_quat_w = r_quat[0];
    assign o_quat_x = r_quat[1];
    assign o_quat_y = r_quat[2];
    assign o_quat_z = r_quat[3];

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input still ready after a transfer");

    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op <= OP_LAST + 6'd1)
        else $error("sequencer op out of range");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && (!r_out_valid || i_ready)) |=> (o_valid && o_ready))
        else $error("finished result not presented");

    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_WAIT))
        else $error("multiplier finished outside of wait");
`endif

endmodule
